>>> hw/rtl/e2bd_pkg.sv
package e2bd_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOURS,
    ST_MINS,
    ST_YEARS,
    ST_MONTHS,
    ST_DONE
  } state_e;

  // Datapath operations commanded by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAYS,
    OP_HOURS,
    OP_MINS,
    OP_YEARS,
    OP_MONTHS,
    OP_OUT
  } op_e;

  // Command from controller to datapath; step 1 is the first cycle of an operation.
  typedef struct packed {
    op_e  op;
    logic step;
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic year_stop;
    logic month_stop;
  } stat_t;

  localparam int unsigned InWidth     = 32;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [8:0]  DaysLeapYr  = 9'd366;
  localparam logic [8:0]  DaysYear    = 9'd365;
  localparam logic [3:0]  LastMonth   = 4'd12;
  localparam logic [7:0]  YearsPerCen = 8'd100;

  // Reciprocals for the divisions by constants. A day is 128 * 675 seconds,
  // an hour 16 * 225 and a minute 4 * 15, so the power-of-two part is a shift.
  localparam logic [25:0] DayRecip   = 26'd50903317;
  localparam int unsigned DayShift   = 35;
  localparam logic [16:0] WeekRecip  = 17'd74899;
  localparam int unsigned WeekShift  = 19;
  localparam logic [13:0] HourRecip  = 14'd9321;
  localparam int unsigned HourShift  = 21;
  localparam logic [10:0] MinRecip   = 11'd1093;
  localparam int unsigned MinShift   = 14;

  // Length of a month in days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m <= 4'd7) begin
      len = m[0] ? 5'd31 : 5'd30;
    end else begin
      len = m[0] ? 5'd30 : 5'd31;
    end
    return len;
  endfunction

  // Two BCD digits of a value below 100; tens digit by reciprocal multiply.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - {3'b000, tens} * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> hw/rtl/e2bd_ctrl.sv
module e2bd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  e2bd_pkg::stat_t stat_i,
  output e2bd_pkg::ctrl_t ctrl_o,
  output logic            busy
);
  import e2bd_pkg::*;

  state_e state_q, state_d;
  logic   step_q, step_d;

  // State and step registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and datapath commands; days, hours and minutes each run with step high, then with step low.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ctrl_o.op   = OP_NONE;
    ctrl_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.op = OP_LOAD;
          step_d    = 1'b1;
          state_d   = ST_DAYS;
        end
      end
      ST_DAYS: begin
        ctrl_o.op = OP_DAYS;
        step_d    = ~step_q;
        if (!step_q) begin
          state_d = ST_HOURS;
        end
      end
      ST_HOURS: begin
        ctrl_o.op = OP_HOURS;
        step_d    = ~step_q;
        if (!step_q) begin
          state_d = ST_MINS;
        end
      end
      ST_MINS: begin
        ctrl_o.op = OP_MINS;
        step_d    = ~step_q;
        if (!step_q) begin
          state_d = ST_YEARS;
        end
      end
      ST_YEARS: begin
        ctrl_o.op = OP_YEARS;
        if (stat_i.year_stop) begin
          state_d = ST_MONTHS;
        end
      end
      ST_MONTHS: begin
        ctrl_o.op = OP_MONTHS;
        if (stat_i.month_stop) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ctrl_o.op = OP_OUT;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> hw/rtl/e2bd_dp.sv
module e2bd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [e2bd_pkg::InWidth-1:0]  seconds_count_i,
  input  e2bd_pkg::ctrl_t               ctrl_i,
  output e2bd_pkg::stat_t               stat_o,
  output logic                          valid_o,
  output logic [2:0]                    weekday_o,
  output logic [6:0]                    seconds_bcd_o,
  output logic [6:0]                    minutes_bcd_o,
  output logic [5:0]                    hours_bcd_o,
  output logic [5:0]                    date_bcd_o,
  output logic [4:0]                    month_bcd_o,
  output logic [7:0]                    year_bcd_o
);
  import e2bd_pkg::*;

  logic [InWidth-1:0] num_q;
  logic [16:0]        rem_q;
  logic [15:0]        days_q;
  logic [13:0]        q7_q;
  logic [2:0]         wk_q;
  logic [4:0]         hours_q;
  logic [5:0]         mins_q;
  logic [7:0]         yoff_q;
  logic [3:0]         month_q;
  logic               valid_q;
  logic [2:0]         wk_out_q;
  logic [7:0]         sec_bcd_q, min_bcd_q, hour_bcd_q, date_bcd_q, mon_bcd_q, year_bcd_q;

  // Whole days: the seconds over 128, then over 675 by reciprocal multiply.
  logic [50:0] day_prod;
  logic [15:0] day_quot;

  assign day_prod = 51'(num_q[InWidth-1:7]) * 51'(DayRecip);
  assign day_quot = 16'(day_prod >> DayShift);

  // Seconds within the day, and the day count over seven for the weekday.
  logic [31:0] day_secs;
  logic [32:0] wk_prod;

  assign day_secs = 32'(days_q) * 32'(SecsPerDay);
  assign wk_prod  = 33'(days_q) * 33'(WeekRecip);

  // Hours and minutes by reciprocal multiply of the remaining seconds.
  logic [26:0] hour_prod;
  logic [20:0] min_prod;

  assign hour_prod = 27'(rem_q[16:4]) * 27'(HourRecip);
  assign min_prod  = 21'(rem_q[11:2]) * 21'(MinRecip);

  // Year and month lengths; 1900 is not leap, 2000 is.
  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;

  assign leap = (yoff_q[1:0] == 2'b00) && (yoff_q != 8'd0);
  assign ylen = leap ? DaysLeapYr : DaysYear;
  assign mlen = month_len(month_q, leap);

  assign stat_o.year_stop  = (days_q < {7'd0, ylen});
  assign stat_o.month_stop = (month_q == LastMonth) || (days_q < {11'd0, mlen});

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD: begin
        num_q   <= seconds_count_i;
        rem_q   <= '0;
        days_q  <= '0;
        q7_q    <= '0;
        wk_q    <= '0;
        hours_q <= '0;
        mins_q  <= '0;
        yoff_q  <= '0;
        month_q <= 4'd1;
      end
      OP_DAYS: begin
        if (ctrl_i.step) begin
          days_q <= day_quot;
        end else begin
          rem_q <= 17'(num_q - day_secs);
          q7_q  <= 14'(wk_prod >> WeekShift);
        end
      end
      OP_HOURS: begin
        if (ctrl_i.step) begin
          hours_q <= 5'(hour_prod >> HourShift);
          wk_q    <= 3'(days_q - {2'b00, q7_q} * 16'd7);
        end else begin
          rem_q <= rem_q - {12'd0, hours_q} * SecsPerHour;
        end
      end
      OP_MINS: begin
        if (ctrl_i.step) begin
          mins_q <= 6'(min_prod >> MinShift);
        end else begin
          rem_q <= rem_q - {11'd0, mins_q} * SecsPerMin;
        end
      end
      OP_YEARS: begin
        if (!stat_o.year_stop) begin
          days_q <= days_q - {7'd0, ylen};
          yoff_q <= yoff_q + 8'd1;
        end
      end
      OP_MONTHS: begin
        if (!stat_o.month_stop) begin
          days_q  <= days_q - {11'd0, mlen};
          month_q <= month_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word: BCD conversion into the output registers.
  logic [6:0] year_lo;
  assign year_lo = (yoff_q >= YearsPerCen) ? 7'(yoff_q - YearsPerCen) : yoff_q[6:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_OUT) begin
      wk_out_q   <= wk_q;
      sec_bcd_q  <= to_bcd(rem_q[6:0]);
      min_bcd_q  <= to_bcd({1'b0, mins_q});
      hour_bcd_q <= to_bcd({2'b00, hours_q});
      date_bcd_q <= to_bcd(7'(days_q[4:0]) + 7'd1);
      mon_bcd_q  <= to_bcd({3'b000, month_q});
      year_bcd_q <= to_bcd(year_lo);
    end
  end

  // Strobe marks the result word for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (ctrl_i.op == OP_OUT);
    end
  end

  assign valid_o       = valid_q;
  assign weekday_o     = wk_out_q;
  assign seconds_bcd_o = sec_bcd_q[6:0];
  assign minutes_bcd_o = min_bcd_q[6:0];
  assign hours_bcd_o   = hour_bcd_q[5:0];
  assign date_bcd_o    = date_bcd_q[5:0];
  assign month_bcd_o   = mon_bcd_q[4:0];
  assign year_bcd_o    = year_bcd_q;

endmodule

>>> hw/rtl/epoch_seconds_to_bcd_date.sv
// Channel  | Handshake                | Word
// ---------+--------------------------+---------------------------------------------
// input    | start (in), busy (out)   | seconds_count_i
// result   | valid_o (one-cycle pulse)| weekday_o, seconds/minutes/hours/date/month/
//          |                          | year_bcd_o
//
// A word is taken when start is high and busy is low; busy stays high until the result.
// valid_o rises as busy falls. Days, hours and minutes are found by reciprocal
// multiply; then whole years are taken off, one subtraction per cycle, and then
// the whole months.
// The next word can be taken at the edge that ends the valid_o cycle.
// valid_o is high for exactly one cycle; the receiver cannot stall it.
// rst_ni clears the controller and the result strobe asynchronously.
module epoch_seconds_to_bcd_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] seconds_count_i,
  output logic        valid_o,
  output logic [2:0]  weekday_o,
  output logic [6:0]  seconds_bcd_o,
  output logic [6:0]  minutes_bcd_o,
  output logic [5:0]  hours_bcd_o,
  output logic [5:0]  date_bcd_o,
  output logic [4:0]  month_bcd_o,
  output logic [7:0]  year_bcd_o
);
  import e2bd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer.
  e2bd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  // Arithmetic and result registers.
  e2bd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seconds_count_i (seconds_count_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .valid_o         (valid_o),
    .weekday_o       (weekday_o),
    .seconds_bcd_o   (seconds_bcd_o),
    .minutes_bcd_o   (minutes_bcd_o),
    .hours_bcd_o     (hours_bcd_o),
    .date_bcd_o      (date_bcd_o),
    .month_bcd_o     (month_bcd_o),
    .year_bcd_o      (year_bcd_o)
  );

endmodule

>>> hw/rtl/e2bd_checker.sv
module e2bd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic [2:0] weekday_o,
  input logic [4:0] month_bcd_o
);

  // An accepted word makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The result strobe lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // Busy ends exactly when the result word is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> valid_o)
    else $error("busy fell without a result");

  // A result word only appears once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result shown while busy");

  // Weekday and month stay in range on every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   valid_o |-> (weekday_o != 3'd7) && (month_bcd_o != 5'd0))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_bcd_date e2bd_checker u_e2bd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .weekday_o   (weekday_o),
  .month_bcd_o (month_bcd_o)
);
